// ===== rtl/plc_cb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLC counter bank package
// Field widths, operation and mode codes, and the item and result records
// shared by the counter bank modules.
// ----------------------------------------------------------------------------
package plc_cb_pkg;

	localparam int FUNC_W   = 3;
	localparam int HANDLE_W = 5;
	localparam int COUNT_W  = 32;
	localparam int KIND_W   = 3;

	// Largest handle the handle field can carry.
	localparam int HANDLE_LIMIT = 31;

	localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_FREE   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CLOCK  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_PRESET = 3'd3;
	localparam logic [FUNC_W-1:0] FN_MODE   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;

	localparam logic [KIND_W-1:0] MODE_NONE      = 3'd0;
	localparam logic [KIND_W-1:0] MODE_UP_RISE   = 3'd1;
	localparam logic [KIND_W-1:0] MODE_UP_FALL   = 3'd2;
	localparam logic [KIND_W-1:0] MODE_UP_HIGH   = 3'd3;
	localparam logic [KIND_W-1:0] MODE_UP_LOW    = 3'd4;
	localparam logic [KIND_W-1:0] MODE_DOWN_RISE = 3'd5;
	localparam logic [KIND_W-1:0] MODE_DOWN_HIGH = 3'd6;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [HANDLE_W-1:0] handle;
		logic                level;
		logic [COUNT_W-1:0]  preset;
		logic [KIND_W-1:0]   kind;
	} op_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [COUNT_W-1:0]  count;
		logic [KIND_W-1:0]   kind;
		logic                ok;
	} res_t;

endpackage

// ===== rtl/plc_cb_free_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLC counter bank free slot finder
// Priority encoder over the slot used flags; yields the lowest free slot.
// ----------------------------------------------------------------------------
module plc_cb_free_find #(
	parameter int SLOTS = 16,
	parameter int IDX_W = 4
) (
	input  logic [SLOTS-1:0] used,
	output logic             found,
	output logic [IDX_W-1:0] idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				found = 1'b1;
				idx   = IDX_W'(i);
			end
		end
	end

endmodule

// ===== rtl/plc_cb_slot_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLC counter bank slot store
// Holds the per-slot flags, modes, levels and counts, executes one operation
// per beat and forms its result.
// ----------------------------------------------------------------------------
module plc_cb_slot_bank #(
	parameter int NUM_COUNTERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              exec,
	input  plc_cb_pkg::op_t   op,
	output plc_cb_pkg::res_t  res
);
	import plc_cb_pkg::*;

	localparam int SLOTS = (NUM_COUNTERS < HANDLE_LIMIT) ? NUM_COUNTERS : HANDLE_LIMIT;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [HANDLE_W-1:0] SLOTS_H = HANDLE_W'(SLOTS);

	logic [SLOTS-1:0]   used_q;
	logic [SLOTS-1:0]   level_q;
	logic [KIND_W-1:0]  mode_q  [SLOTS];
	logic [COUNT_W-1:0] count_q [SLOTS];

	logic                free_found;
	logic [IDX_W-1:0]    free_idx;
	logic [HANDLE_W-1:0] h_minus;
	logic [IDX_W-1:0]    idx;
	logic                in_range;
	logic                hit;
	logic [COUNT_W-1:0]  cur_count;
	logic [KIND_W-1:0]   cur_mode;
	logic                cur_level;
	logic [COUNT_W-1:0]  clk_count;
	logic                rise;
	logic                fall;

	plc_cb_free_find #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_free_find (
		.used  (used_q),
		.found (free_found),
		.idx   (free_idx)
	);

	assign h_minus  = op.handle - HANDLE_W'(1);
	assign idx      = h_minus[IDX_W-1:0];
	assign in_range = (op.handle != '0) && (op.handle <= SLOTS_H);
	assign hit      = in_range && used_q[idx];

	assign cur_count = count_q[idx];
	assign cur_mode  = mode_q[idx];
	assign cur_level = level_q[idx];
	assign rise      = op.level && !cur_level;
	assign fall      = !op.level && cur_level;

	always_comb begin
		clk_count = cur_count;
		case (cur_mode)
			MODE_UP_RISE:   if (rise) clk_count = cur_count + COUNT_W'(1);
			MODE_UP_FALL:   if (fall) clk_count = cur_count + COUNT_W'(1);
			MODE_UP_HIGH:   if (op.level) clk_count = cur_count + COUNT_W'(1);
			MODE_UP_LOW:    if (!op.level) clk_count = cur_count + COUNT_W'(1);
			MODE_DOWN_RISE: if (rise && cur_count != '0) clk_count = cur_count - COUNT_W'(1);
			MODE_DOWN_HIGH: if (op.level && cur_count != '0) clk_count = cur_count - COUNT_W'(1);
			default:        clk_count = cur_count;
		endcase
	end

	always_comb begin
		res = '0;
		case (op.func)
			FN_ALLOC: begin
				if (free_found) begin
					res.handle_out = HANDLE_W'(free_idx) + HANDLE_W'(1);
					res.ok         = 1'b1;
				end
			end
			FN_FREE: begin
				res.ok = hit;
			end
			FN_CLOCK: begin
				if (hit) begin
					res.count = clk_count;
					res.kind  = cur_mode;
					res.ok    = 1'b1;
				end
			end
			FN_PRESET: begin
				if (hit) begin
					res.count = op.preset;
					res.kind  = cur_mode;
					res.ok    = 1'b1;
				end
			end
			FN_MODE: begin
				if (hit) begin
					res.count = cur_count;
					res.kind  = op.kind;
					res.ok    = 1'b1;
				end
			end
			FN_READ: begin
				if (hit) begin
					res.count = cur_count;
					res.kind  = cur_mode;
					res.ok    = 1'b1;
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (exec) begin
			if (op.func == FN_ALLOC && free_found) used_q[free_idx] <= 1'b1;
			if (op.func == FN_FREE && hit) used_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			if (op.func == FN_ALLOC && free_found) begin
				count_q[free_idx] <= '0;
				mode_q[free_idx]  <= MODE_NONE;
				level_q[free_idx] <= 1'b0;
			end
			if (hit) begin
				case (op.func)
					FN_CLOCK: begin
						count_q[idx] <= clk_count;
						level_q[idx] <= op.level;
					end
					FN_PRESET: count_q[idx] <= op.preset;
					FN_MODE:   mode_q[idx]  <= op.kind;
					default:   ;
				endcase
			end
		end
	end

	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		exec && op.func == FN_FREE && hit |=> !used_q[$past(idx)])
		else $error("freed slot still marked used");

	a_alloc_claims: assert property (@(posedge clk) disable iff (!arst_n)
		exec && op.func == FN_ALLOC && free_found |=> used_q[$past(free_idx)])
		else $error("allocated slot not marked used");

endmodule

// ===== rtl/plc_counter_bank_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLC counter bank core
// Bank of up/down PLC counters addressed by handle, one operation per beat.
//
//   channel | dir | payload
//   --------+-----+--------------------------------------------------------
//   s_*     | in  | tuser: func; tdata: handle, level, preset, kind
//   m_*     | out | tuser: handle_ok; tdata: handle_out, count_out, kind_out
//
// One beat per cycle while m_tready keeps the output flowing; a beat goes
// into the input register, then its result into the result register.
// The input and result registers each hold one beat, so a new beat is taken
// while a finished result waits on m_tready, provided the input register is empty.
// Reset marks all slots free; no clearing pass is needed.
// ----------------------------------------------------------------------------
module plc_counter_bank_core #(
	parameter int NUM_COUNTERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // handle[4:0], level[5], preset[37:6], kind[40:38]
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // handle_out[4:0], count_out[36:5], kind_out[39:37]
	output logic        m_tuser   // handle_ok[0]
);
	import plc_cb_pkg::*;

	op_t  op_in;
	op_t  op_s1;
	logic valid_s1;
	res_t res;
	res_t res_q;
	logic valid_q;
	logic advance;

	assign op_in.func   = s_tuser;
	assign op_in.handle = s_tdata[4:0];
	assign op_in.level  = s_tdata[5];
	assign op_in.preset = s_tdata[37:6];
	assign op_in.kind   = s_tdata[40:38];

	assign advance  = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) op_s1 <= op_in;
	end

	plc_cb_slot_bank #(
		.NUM_COUNTERS (NUM_COUNTERS)
	) u_slot_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.exec   (advance),
		.op     (op_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.kind, res_q.count, res_q.handle_out};
	assign m_tuser  = res_q.ok;

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_q && !m_tready |-> !s_tready)
		else $error("input taken while both stages are held");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_q.ok |-> res_q.count == '0 && res_q.kind == '0
			&& res_q.handle_out == '0)
		else $error("rejected beat carries nonzero fields");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.handle_out != '0 |-> res_q.ok && res_q.count == '0)
		else $error("granted handle without clean slot");

endmodule
